>>> rtl/getf_pkg.sv
package getf_pkg;

   localparam int MAX_DIM     = 4096;
   localparam int COORD_W     = 12;
   localparam int COORD_LIMIT = (MAX_DIM - 1 > 4095) ? 4095 : MAX_DIM - 1;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam int T_W   = 17;
   localparam logic [T_W-1:0] T_ONE = 17'h10000;

   localparam int DIFF_W   = 30;
   localparam int SCALED_W = 46;

   // register index codes
   localparam logic [2:0] REG_TOP_RGB    = 3'd0;
   localparam logic [2:0] REG_BOTTOM_RGB = 3'd1;
   localparam logic [2:0] REG_GAIN       = 3'd2;
   localparam logic [2:0] REG_DIR_COS    = 3'd3;
   localparam logic [2:0] REG_DIR_SIN    = 3'd4;
   localparam logic [2:0] REG_PROJ_MIN   = 3'd5;
   localparam logic [2:0] REG_RANGE_RCP  = 3'd6;

   typedef struct packed {
      logic [23:0]        top_rgb;
      logic [23:0]        bottom_rgb;
      logic [11:0]        gain;
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
      logic signed [27:0] proj_min;
      logic [16:0]        range_rcp;
   } getf_cfg_type;

   typedef struct packed {
      logic           valid;
      logic [7:0]     alpha;
      logic [T_W-1:0] t;
   } getf_tpos_type;

endpackage

>>> rtl/gradient_emissive_text_fill.sv
// pipeline of seven register stages: products, offset, scale, clamp, blend, gain, pack
// throughput: one word per clock, busy stays low, start may be high every cycle
// the receiver cannot stall, so rsp_valid is a one-cycle strobe per word
// synchronous active-high reset clears the valid bits and loads register defaults
module gradient_emissive_text_fill (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [getf_pkg::COORD_W-1:0]  req_pixel_x,
   input  logic [getf_pkg::COORD_W-1:0]  req_pixel_y,
   input  logic [7:0]                    req_coverage_alpha,
   output logic                          rsp_valid,
   output logic [31:0]                   rsp_pixel_argb,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [getf_pkg::ADDR_W-1:0]   paddr,
   input  logic [getf_pkg::DATA_W-1:0]   pwdata,
   output logic [getf_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   getf_pkg::getf_cfg_type  cfg;
   getf_pkg::getf_tpos_type tpos;
   logic                    accept;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   getf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   getf_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .pixel_x  (req_pixel_x),
      .pixel_y  (req_pixel_y),
      .alpha    (req_coverage_alpha),
      .cfg      (cfg),
      .tpos     (tpos)
   );

   getf_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .tpos      (tpos),
      .cfg       (cfg),
      .out_valid (rsp_valid),
      .out_argb  (rsp_pixel_argb)
   );

   a_word_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_valid)
      else $error("accepted word produced no result");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 7))
      else $error("result without accepted word");

endmodule

>>> rtl/getf_csr.sv
module getf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [getf_pkg::ADDR_W-1:0]   paddr,
   input  logic [getf_pkg::DATA_W-1:0]   pwdata,
   output logic [getf_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output getf_pkg::getf_cfg_type        cfg
);

   getf_pkg::getf_cfg_type cfg_ff;
   getf_pkg::getf_cfg_type cfg_in;
   logic                   wr_en;
   logic [2:0]             reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_idx = paddr[getf_pkg::ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            getf_pkg::REG_TOP_RGB:    cfg_in.top_rgb    = pwdata[23:0];
            getf_pkg::REG_BOTTOM_RGB: cfg_in.bottom_rgb = pwdata[23:0];
            getf_pkg::REG_GAIN:       cfg_in.gain       = pwdata[11:0];
            getf_pkg::REG_DIR_COS:    cfg_in.dir_cos    = $signed(pwdata[15:0]);
            getf_pkg::REG_DIR_SIN:    cfg_in.dir_sin    = $signed(pwdata[15:0]);
            getf_pkg::REG_PROJ_MIN:   cfg_in.proj_min   = $signed(pwdata[27:0]);
            getf_pkg::REG_RANGE_RCP:  cfg_in.range_rcp  = pwdata[16:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_rgb    <= 24'hFFFFFF;
         cfg_ff.bottom_rgb <= 24'hFFFFFF;
         cfg_ff.gain       <= 12'd256;
         cfg_ff.dir_cos    <= 16'sd0;
         cfg_ff.dir_sin    <= 16'sd16384;
         cfg_ff.proj_min   <= 28'sd0;
         cfg_ff.range_rcp  <= 17'h10000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         getf_pkg::REG_TOP_RGB:    prdata = {8'd0, cfg_ff.top_rgb};
         getf_pkg::REG_BOTTOM_RGB: prdata = {8'd0, cfg_ff.bottom_rgb};
         getf_pkg::REG_GAIN:       prdata = {20'd0, cfg_ff.gain};
         getf_pkg::REG_DIR_COS:    prdata = {{16{cfg_ff.dir_cos[15]}}, cfg_ff.dir_cos};
         getf_pkg::REG_DIR_SIN:    prdata = {{16{cfg_ff.dir_sin[15]}}, cfg_ff.dir_sin};
         getf_pkg::REG_PROJ_MIN:   prdata = {{4{cfg_ff.proj_min[27]}}, cfg_ff.proj_min};
         getf_pkg::REG_RANGE_RCP:  prdata = {15'd0, cfg_ff.range_rcp};
         default:                  prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/getf_proj.sv
module getf_proj (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [getf_pkg::COORD_W-1:0]    pixel_x,
   input  logic [getf_pkg::COORD_W-1:0]    pixel_y,
   input  logic [7:0]                      alpha,
   input  getf_pkg::getf_cfg_type          cfg,
   output getf_pkg::getf_tpos_type         tpos
);

   localparam logic [getf_pkg::COORD_W-1:0] CoordMax =
      getf_pkg::COORD_W'(getf_pkg::COORD_LIMIT);

   logic [getf_pkg::COORD_W-1:0] x_sat;
   logic [getf_pkg::COORD_W-1:0] y_sat;

   // stage 1: coordinate products
   logic               v1_ff;
   logic [7:0]         alpha1_ff;
   logic signed [28:0] prod_x1_ff, prod_x1_in;
   logic signed [28:0] prod_y1_ff, prod_y1_in;

   // stage 2: offset projection
   logic                                v2_ff;
   logic [7:0]                          alpha2_ff;
   logic signed [getf_pkg::DIFF_W-1:0]  diff2_ff, diff2_in;

   // stage 3: scale by reciprocal range
   logic                                v3_ff;
   logic [7:0]                          alpha3_ff;
   logic                                pos3_ff, pos3_in;
   logic [getf_pkg::SCALED_W-1:0]       scaled3_ff, scaled3_in;

   // stage 4: clamp to [0, 1]
   logic                                v4_ff;
   logic [7:0]                          alpha4_ff;
   logic [getf_pkg::T_W-1:0]            t4_ff, t4_in;

   assign x_sat = (pixel_x > CoordMax) ? CoordMax : pixel_x;
   assign y_sat = (pixel_y > CoordMax) ? CoordMax : pixel_y;

   assign prod_x1_in = $signed({1'b0, x_sat}) * cfg.dir_cos;
   assign prod_y1_in = $signed({1'b0, y_sat}) * cfg.dir_sin;

   assign diff2_in = getf_pkg::DIFF_W'(prod_x1_ff) + getf_pkg::DIFF_W'(prod_y1_ff)
                   - getf_pkg::DIFF_W'(cfg.proj_min);

   assign pos3_in    = !diff2_ff[getf_pkg::DIFF_W-1] && (diff2_ff != '0);
   assign scaled3_in = diff2_ff[getf_pkg::DIFF_W-2:0] * cfg.range_rcp;

   always_comb begin
      if (!pos3_ff) begin
         t4_in = '0;
      end else if (scaled3_ff[getf_pkg::SCALED_W-1:14] > 32'(getf_pkg::T_ONE)) begin
         t4_in = getf_pkg::T_ONE;
      end else begin
         t4_in = scaled3_ff[getf_pkg::T_W+13:14];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      alpha1_ff  <= alpha;
      prod_x1_ff <= prod_x1_in;
      prod_y1_ff <= prod_y1_in;
      alpha2_ff  <= alpha1_ff;
      diff2_ff   <= diff2_in;
      alpha3_ff  <= alpha2_ff;
      pos3_ff    <= pos3_in;
      scaled3_ff <= scaled3_in;
      alpha4_ff  <= alpha3_ff;
      t4_ff      <= t4_in;
   end

   assign tpos.valid = v4_ff;
   assign tpos.alpha = alpha4_ff;
   assign tpos.t     = t4_ff;

   a_t_bounded: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> (t4_ff <= getf_pkg::T_ONE))
      else $error("gradient position above one");

   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (v4_ff == $past(v1_ff, 3)) || $past(reset, 3) || $past(reset, 2))
      else $error("valid lost or invented inside projection pipe");

endmodule

>>> rtl/getf_shade.sv
module getf_shade (
   input  logic                     clock,
   input  logic                     reset,
   input  getf_pkg::getf_tpos_type  tpos,
   input  getf_pkg::getf_cfg_type   cfg,
   output logic                     out_valid,
   output logic [31:0]              out_argb
);

   localparam int Lanes = 3;

   logic [getf_pkg::T_W-1:0] inv_t;

   // stage 5: weighted colour terms
   logic        v5_ff;
   logic [7:0]  alpha5_ff;
   logic [24:0] wt_top5_ff [Lanes];
   logic [24:0] wt_bot5_ff [Lanes];
   logic [24:0] wt_top5_in [Lanes];
   logic [24:0] wt_bot5_in [Lanes];

   // stage 6: blended channel times gain
   logic        v6_ff;
   logic [7:0]  alpha6_ff;
   logic [19:0] gained6_ff [Lanes];
   logic [19:0] gained6_in [Lanes];
   logic [24:0] blend_sum  [Lanes];

   // stage 7: saturate and pack
   logic        v7_ff;
   logic [31:0] argb7_ff, argb7_in;
   logic [7:0]  chan_sat   [Lanes];
   logic [11:0] chan_full  [Lanes];

   assign inv_t = getf_pkg::T_ONE - tpos.t;

   for (genvar i = 0; i < Lanes; i++) begin : g_lane
      assign wt_top5_in[i] = 25'(cfg.top_rgb[8*i +: 8] * inv_t);
      assign wt_bot5_in[i] = 25'(cfg.bottom_rgb[8*i +: 8] * tpos.t);
      assign blend_sum[i]  = wt_top5_ff[i] + wt_bot5_ff[i];
      assign gained6_in[i] = blend_sum[i][23:16] * cfg.gain;
      assign chan_full[i]  = gained6_ff[i][19:8];
      assign chan_sat[i]   = (chan_full[i] > 12'd255) ? 8'hFF : chan_full[i][7:0];

      always_ff @(posedge clock) begin
         wt_top5_ff[i] <= wt_top5_in[i];
         wt_bot5_ff[i] <= wt_bot5_in[i];
         gained6_ff[i] <= gained6_in[i];
      end
   end

   // transparent pixels give an all-zero word
   assign argb7_in = (alpha6_ff == 8'd0) ? 32'd0
                   : {alpha6_ff, chan_sat[2], chan_sat[1], chan_sat[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else begin
         v5_ff <= tpos.valid;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      alpha5_ff <= tpos.alpha;
      alpha6_ff <= alpha5_ff;
      argb7_ff  <= argb7_in;
   end

   assign out_valid = v7_ff;
   assign out_argb  = argb7_ff;

   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      (v7_ff && (argb7_ff[31:24] == 8'd0)) |-> (argb7_ff == 32'd0))
      else $error("transparent word carries colour");

endmodule
